/* rtl/lsc_pkg.sv */
// Shared constants and types for the log spectrum compressor.
// No dependencies; every rtl file refers to it by scoped names.
package lsc_pkg;

  localparam int FRAC_BITS  = 16;   // fraction bits of the result (8..24)
  localparam int IN_FRAC    = 16;   // fraction bits of the coefficient parts
  localparam int WORK_FRAC  = 24;   // fraction bits of the internal log2
  localparam int OUT_W      = 22;
  localparam int IN_W       = 32;
  localparam int GAIN_W     = 10;
  localparam int V_W        = 42;   // 1.0 + x, x below 2^41
  localparam int P_W        = 6;    // index of the top set bit of v
  localparam int INT_W      = 5;    // integer part of log2(v) - 16, at most 25
  localparam int L2_W       = INT_W + WORK_FRAC;
  localparam int Z_W        = 31;   // mantissa, Q1.30
  localparam int SQ_STAGES  = 16;   // two root bits per stage
  localparam int SQ_REM_W   = 36;
  localparam int SQ_ROOT_W  = 32;
  localparam int LOG_ITERS  = WORK_FRAC;
  localparam int OUT_SHIFT  = WORK_FRAC - FRAC_BITS;
  localparam int CFG_IDX_W  = 1;

  localparam logic [31:0]      LOG10_2_Q32 = 32'h4D10_4D42;
  localparam logic [V_W-1:0]   V_ONE       = V_W'(1) << IN_FRAC;
  localparam logic [OUT_W-1:0] OUT_MAX     = {OUT_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_SPECTRUM_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_GAIN     = 1'b1;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    logic           mode;
    logic [V_W-1:0] gain_mag;
  } side_t;

endpackage

/* rtl/lsc_front.sv */
// Front end: magnitudes, squares, gain product and sum of squares.
// Depends on lsc_pkg.
module lsc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic signed [31:0]          real_part,
  input  logic signed [31:0]          imag_part,
  input  logic                        mode,
  input  logic [lsc_pkg::GAIN_W-1:0]  gain,
  output logic                        out_vld,
  output logic [63:0]                 sum_sq,
  output lsc_pkg::side_t              side
);

  logic [31:0] re_abs, im_abs;
  logic        vld1_r, vld2_r;
  logic [63:0] re2_r, im2_r, sum_r;
  lsc_pkg::side_t side1_r, side2_r;

  assign re_abs = real_part[31] ? 32'(-real_part) : 32'(real_part);
  assign im_abs = imag_part[31] ? 32'(-imag_part) : 32'(imag_part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re2_r            <= 64'(re_abs) * 64'(re_abs);
      im2_r            <= 64'(im_abs) * 64'(im_abs);
      side1_r.mode     <= mode;
      side1_r.gain_mag <= lsc_pkg::V_W'(gain) * lsc_pkg::V_W'(re_abs);
      sum_r            <= re2_r + im2_r;
      side2_r          <= side1_r;
    end
  end

  assign out_vld = vld2_r;
  assign sum_sq  = sum_r;
  assign side    = side2_r;

endmodule

/* rtl/lsc_isqrt.sv */
// Pipelined restoring integer square root, two root bits per stage.
// Depends on lsc_pkg.
module lsc_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [63:0]                    sum_sq,
  input  lsc_pkg::side_t                 in_side,
  output logic                           out_vld,
  output logic [lsc_pkg::SQ_ROOT_W-1:0]  root,
  output lsc_pkg::side_t                 out_side
);

  typedef struct packed {
    logic [lsc_pkg::SQ_REM_W-1:0]  rem;
    logic [lsc_pkg::SQ_ROOT_W-1:0] root;
  } sq_t;

  function automatic sq_t sq_iter(sq_t x, logic [1:0] b);
    sq_t                          y;
    logic [lsc_pkg::SQ_REM_W-1:0] cur;
    logic [lsc_pkg::SQ_REM_W-1:0] trial;
    cur   = {x.rem[lsc_pkg::SQ_REM_W-3:0], b};
    trial = {2'b00, x.root, 2'b01};
    if (cur >= trial) begin
      y.rem  = cur - trial;
      y.root = {x.root[lsc_pkg::SQ_ROOT_W-2:0], 1'b1};
    end else begin
      y.rem  = cur;
      y.root = {x.root[lsc_pkg::SQ_ROOT_W-2:0], 1'b0};
    end
    return y;
  endfunction

  logic           vld_r  [lsc_pkg::SQ_STAGES+1];
  sq_t            st_r   [lsc_pkg::SQ_STAGES+1];
  logic [63:0]    s_r    [lsc_pkg::SQ_STAGES+1];
  lsc_pkg::side_t side_r [lsc_pkg::SQ_STAGES+1];

  // Stage 0 is the input itself.
  assign vld_r[0]  = in_vld;
  assign st_r[0]   = '0;
  assign s_r[0]    = sum_sq;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < lsc_pkg::SQ_STAGES; k++) begin : g_stage
    sq_t a, b;
    assign a = sq_iter(st_r[k], s_r[k][63-4*k -: 2]);
    assign b = sq_iter(a,       s_r[k][61-4*k -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1]   <= b;
        s_r[k+1]    <= s_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[lsc_pkg::SQ_STAGES];
  assign root     = st_r[lsc_pkg::SQ_STAGES].root;
  assign out_side = side_r[lsc_pkg::SQ_STAGES];

endmodule

/* rtl/lsc_log2.sv */
// Pipelined log2: leading-one search, normalize, then one squaring per stage.
// Depends on lsc_pkg.
module lsc_log2 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic                        in_mode,
  input  logic [lsc_pkg::V_W-1:0]     v,
  output logic                        out_vld,
  output logic                        out_mode,
  output logic [lsc_pkg::L2_W-1:0]    l2
);

  localparam int N = lsc_pkg::LOG_ITERS;

  logic [lsc_pkg::P_W-1:0] p_srch;
  logic                    vldp_r, modep_r;
  logic [lsc_pkg::V_W-1:0] vp_r;

  logic                          vld_r  [N+1];
  logic                          mode_r [N+1];
  logic [lsc_pkg::Z_W-1:0]       z_r    [N+1];
  logic [lsc_pkg::WORK_FRAC-1:0] fr_r   [N+1];
  logic [lsc_pkg::INT_W-1:0]     ip_r   [N+1];

  always_comb begin
    p_srch = '0;
    for (int i = 0; i < lsc_pkg::V_W; i++) begin
      if (vp_r[i] == 1'b0) begin
        p_srch = p_srch;
      end else begin
        p_srch = lsc_pkg::P_W'(i);
      end
    end
  end

  // Search stage: hold v, find its top bit one stage later.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldp_r <= 1'b0;
    end else if (en) begin
      vldp_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vp_r    <= v;
      modep_r <= in_mode;
    end
  end

  // Normalize stage uses the registered search result.
  logic                    vldn_r, moden_r;
  logic [lsc_pkg::V_W-1:0] vn_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldn_r <= 1'b0;
    end else if (en) begin
      vldn_r <= vldp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vn_r    <= vp_r;
      moden_r <= modep_r;
    end
  end

  logic [lsc_pkg::P_W-1:0] pn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pn_r <= p_srch;
    end
  end

  logic [lsc_pkg::Z_W-1:0] z_norm;
  assign z_norm = (pn_r >= lsc_pkg::P_W'(30)) ?
                  lsc_pkg::Z_W'(vn_r >> (pn_r - lsc_pkg::P_W'(30))) :
                  lsc_pkg::Z_W'(vn_r << (lsc_pkg::P_W'(30) - pn_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vldn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_r[0] <= moden_r;
      z_r[0]    <= z_norm;
      fr_r[0]   <= '0;
      ip_r[0]   <= lsc_pkg::INT_W'(pn_r - lsc_pkg::P_W'(lsc_pkg::IN_FRAC));
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_sq
    logic [2*lsc_pkg::Z_W-1:0] sq;
    logic [31:0]               t;
    assign sq = (2*lsc_pkg::Z_W)'(z_r[i]) * (2*lsc_pkg::Z_W)'(z_r[i]);
    assign t  = 32'(sq >> 30);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mode_r[i+1] <= mode_r[i];
        ip_r[i+1]   <= ip_r[i];
        fr_r[i+1]   <= {fr_r[i][lsc_pkg::WORK_FRAC-2:0], t[31]};
        z_r[i+1]    <= t[31] ? t[31:1] : t[30:0];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_mode = mode_r[N];
  assign l2       = {ip_r[N], fr_r[N]};

  // A valid mantissa is always normalized to [1, 2).
  a_z_norm: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> z_r[0][lsc_pkg::Z_W-1])
    else $error("log2 mantissa not normalized");

endmodule

/* rtl/log_spectrum_compress_top.sv */
// Top level of the log spectrum compressor: config registers, stage glue, output.
// Depends on lsc_pkg, lsc_front, lsc_isqrt, lsc_log2.
//
// Usage:
//   Input channel: in_valid / in_stall with in_real_part and in_imag_part
//   (signed Q16.16). Result channel: out_valid / out_stall with
//   out_log_value (unsigned, FRAC_BITS fraction bits). An item moves on a
//   rising edge where valid is high and stall is low.
//   spectrum_mode 0 gives log10(1 + |re + j im|); 1 gives log2(1 + |gain*re|).
//   Write cfg_* only while no item is in flight.
//   Throughput: one item per cycle while the receiver does not stall. The
//   pipe holds the square root (16 stages, two root bits each) and the
//   log2 (24 stages, one squaring multiply each), plus front end, 1.0 + x,
//   search, normalize, scale and output stages.
//   Reset clears every valid bit and loads spectrum_mode = 0, real_gain = 32.
//   When the receiver stalls a valid result, the whole pipe holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
module log_spectrum_compress_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             in_real_part,
  input  logic signed [31:0]             in_imag_part,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lsc_pkg::OUT_W-1:0]      out_log_value,
  input  logic                           cfg_we,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsc_pkg::GAIN_W-1:0]     cfg_data
);

  logic                        spectrum_mode_r;
  logic [lsc_pkg::GAIN_W-1:0]  real_gain_r;
  logic                        en;
  logic                        out_valid_r;

  // Advance everything unless a finished result is held by the receiver.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spectrum_mode_r <= 1'b0;
      real_gain_r     <= lsc_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsc_pkg::CFG_SPECTRUM_MODE: spectrum_mode_r <= cfg_data[0];
        lsc_pkg::CFG_REAL_GAIN:     real_gain_r     <= cfg_data;
        default:                    spectrum_mode_r <= spectrum_mode_r;
      endcase
    end
  end

  // Front end: magnitudes, squares, gain product.
  logic           fr_vld;
  logic [63:0]    fr_sum;
  lsc_pkg::side_t fr_side;

  lsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .real_part (in_real_part),
    .imag_part (in_imag_part),
    .mode      (spectrum_mode_r),
    .gain      (real_gain_r),
    .out_vld   (fr_vld),
    .sum_sq    (fr_sum),
    .side      (fr_side)
  );

  // Square root of the sum of squares; real-mode data rides alongside.
  logic                          sq_vld;
  logic [lsc_pkg::SQ_ROOT_W-1:0] sq_root;
  lsc_pkg::side_t                sq_side;

  lsc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .sum_sq   (fr_sum),
    .in_side  (fr_side),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // Form 1.0 + x for the selected mode.
  logic                    v_vld_r, v_mode_r;
  logic [lsc_pkg::V_W-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_vld_r <= 1'b0;
    end else if (en) begin
      v_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_mode_r <= sq_side.mode;
      v_r      <= (sq_side.mode ? sq_side.gain_mag : lsc_pkg::V_W'(sq_root))
                  + lsc_pkg::V_ONE;
    end
  end

  logic                     lg_vld, lg_mode;
  logic [lsc_pkg::L2_W-1:0] lg_l2;

  lsc_log2 u_log2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v_vld_r),
    .in_mode  (v_mode_r),
    .v        (v_r),
    .out_vld  (lg_vld),
    .out_mode (lg_mode),
    .l2       (lg_l2)
  );

  // Convert to log10 in complex mode: multiply by log10(2) in Q0.32.
  logic                     m_vld_r;
  logic [lsc_pkg::L2_W-1:0] m_res_r;
  logic [lsc_pkg::L2_W+31:0] prod;

  assign prod = (lsc_pkg::L2_W+32)'(lg_l2) * (lsc_pkg::L2_W+32)'(lsc_pkg::LOG10_2_Q32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= lg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_res_r <= lg_mode ? lg_l2 : lsc_pkg::L2_W'(prod >> 32);
    end
  end

  // Output register: drop extra fraction bits, saturate.
  logic [lsc_pkg::L2_W-1:0]  scaled;
  logic [lsc_pkg::OUT_W-1:0] out_log_value_r;

  assign scaled = m_res_r >> lsc_pkg::OUT_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_log_value_r <= (scaled > lsc_pkg::L2_W'(lsc_pkg::OUT_MAX)) ?
                         lsc_pkg::OUT_MAX : lsc_pkg::OUT_W'(scaled);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_log_value = out_log_value_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
